// ===== rtl/salsa20_stream_cipher_defines.svh =====
// ----------------------------------------------------------------------------
// salsa20 stream cipher assertion macros
// concurrent checks on the core clock, removed when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SALSA20_STREAM_CIPHER_DEFINES_SVH
`define SALSA20_STREAM_CIPHER_DEFINES_SVH

`ifndef SYNTH
// check held off while reset is asserted
`define S20_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("salsa20 check failed");
// check that also covers cycles under reset
`define S20_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("salsa20 reset check failed");
`else
`define S20_ASSERT(lbl, prop)
`define S20_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== rtl/s20_pkg.sv =====
// ----------------------------------------------------------------------------
// s20_pkg
// shared types, constants and helper functions of the salsa20 stream cipher
// ----------------------------------------------------------------------------
package s20_pkg;

    // default number of double rounds (salsa20/20)
    localparam int DOUBLE_ROUNDS_DEF = 10;

    // input queue depth between front and core, power of two
    localparam int QUEUE_DEPTH = 2;

    // sigma constants
    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_KEY_0 = 3'd0,
        REG_KEY_1 = 3'd1,
        REG_KEY_2 = 3'd2,
        REG_KEY_3 = 3'd3,
        REG_NONCE = 3'd4
    } t_reg_idx;

    // configuration held for the core
    typedef struct packed {
        logic [63:0] key_0;
        logic [63:0] key_1;
        logic [63:0] key_2;
        logic [63:0] key_3;
        logic [63:0] nonce;
    } t_cfg;

    // one queued input word
    typedef struct packed {
        logic       last;
        logic       first;
        logic [7:0] data;
    } t_item;

    // sixteen-word salsa state
    typedef logic [15:0][31:0] t_words;

    // core sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL
    } t_state;

    // quarter-round word indexes: [column/row][lane][a,b,c,d]
    localparam logic [3:0] QR_IDX [0:1][0:3][0:3] = '{
        '{ '{4'd0,  4'd4,  4'd8,  4'd12},
           '{4'd5,  4'd9,  4'd13, 4'd1 },
           '{4'd10, 4'd14, 4'd2,  4'd6 },
           '{4'd15, 4'd3,  4'd7,  4'd11} },
        '{ '{4'd0,  4'd1,  4'd2,  4'd3 },
           '{4'd5,  4'd6,  4'd7,  4'd4 },
           '{4'd10, 4'd11, 4'd8,  4'd9 },
           '{4'd15, 4'd12, 4'd13, 4'd14} }
    };

    // left rotate by the amount of the given quarter-round step
    function automatic logic [31:0] rol_step(logic [31:0] x, logic [1:0] step);
        logic [31:0] r;
        case (step)
            2'd0: r = {x[24:0], x[31:25]};
            2'd1: r = {x[22:0], x[31:23]};
            2'd2: r = {x[18:0], x[31:19]};
            2'd3: r = {x[13:0], x[31:14]};
            default: r = x;
        endcase
        return r;
    endfunction

    // initial block state from key, nonce and block counter
    function automatic t_words init_state(t_cfg cfg, logic [63:0] ctr);
        t_words s;
        s[0]  = SIGMA_0;
        s[1]  = cfg.key_0[31:0];
        s[2]  = cfg.key_0[63:32];
        s[3]  = cfg.key_1[31:0];
        s[4]  = cfg.key_1[63:32];
        s[5]  = SIGMA_1;
        s[6]  = cfg.nonce[31:0];
        s[7]  = cfg.nonce[63:32];
        s[8]  = ctr[31:0];
        s[9]  = ctr[63:32];
        s[10] = SIGMA_2;
        s[11] = cfg.key_2[31:0];
        s[12] = cfg.key_2[63:32];
        s[13] = cfg.key_3[31:0];
        s[14] = cfg.key_3[63:32];
        s[15] = SIGMA_3;
        return s;
    endfunction

endpackage

// ===== rtl/s20_regs.sv =====
// ----------------------------------------------------------------------------
// s20_regs
// configuration register bank: key and nonce, written by index
// ----------------------------------------------------------------------------
module s20_regs
    import s20_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // index decode, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_KEY_0: n_cfg.key_0 = i_cfg_data;
                REG_KEY_1: n_cfg.key_1 = i_cfg_data;
                REG_KEY_2: n_cfg.key_2 = i_cfg_data;
                REG_KEY_3: n_cfg.key_3 = i_cfg_data;
                REG_NONCE: n_cfg.nonce = i_cfg_data;
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/s20_front.sv =====
// ----------------------------------------------------------------------------
// s20_front
// input side: takes stream words and queues them for the core
// ----------------------------------------------------------------------------
module s20_front
    import s20_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_head_valid,
    output t_item o_head,
    input  logic  i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_ready      = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_pop && (r_count != '0);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers wrap naturally since the depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/s20_core.sv =====
// ----------------------------------------------------------------------------
// s20_core
// keystream engine: builds salsa20 blocks with four quarter-round lanes,
// one add-rotate-xor step per lane per cycle, and combines queued words
// ----------------------------------------------------------------------------
`include "salsa20_stream_cipher_defines.svh"

module s20_core
    import s20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_head_valid,
    input  t_item      i_head,
    output logic       o_pop,
    output logic       o_m_valid,
    input  logic       i_m_ready,
    output logic [7:0] o_m_data,
    output logic       o_m_last
);

    localparam int DR_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

    t_state            r_state, n_state;
    t_words            r_w, n_w;
    logic [63:0]       r_ctr, n_ctr;
    logic [5:0]        r_pos, n_pos;
    logic              r_ready, n_ready;
    logic              r_applied, n_applied;
    logic [1:0]        r_step, n_step;
    logic              r_half, n_half;
    logic [DR_W-1:0]   r_dr, n_dr;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;

    logic              w_eff_first;
    logic              w_out_free;
    logic [63:0]       w_ctr_base;
    logic              w_pop;
    logic              w_start;

    // a first flag counts once, on the block it triggers
    assign w_eff_first = i_head.first && !r_applied;
    assign w_out_free  = !r_out_valid || i_m_ready;
    assign w_ctr_base  = w_eff_first ? 64'd0 : r_ctr;

    // sequencer, round datapath and byte combine
    always_comb begin
        logic [1:0]  v_rt;
        logic [1:0]  v_ry;
        logic [3:0]  v_t;
        logic [3:0]  v_x;
        logic [3:0]  v_y;
        logic [31:0] v_word;
        t_words      v_init;

        n_state     = r_state;
        n_w         = r_w;
        n_ctr       = r_ctr;
        n_pos       = r_pos;
        n_ready     = r_ready;
        n_applied   = r_applied;
        n_step      = r_step;
        n_half      = r_half;
        n_dr        = r_dr;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        w_pop       = 1'b0;
        w_start     = 1'b0;
        v_rt        = r_step + 2'd1;
        v_ry        = r_step - 2'd1;
        v_t         = '0;
        v_x         = '0;
        v_y         = '0;
        v_word      = r_w[r_pos[5:2]];
        v_init      = init_state(i_cfg, r_ctr);

        if (r_out_valid && i_m_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    if (w_eff_first || !r_ready) begin
                        // load a fresh block state
                        w_start   = 1'b1;
                        n_ctr     = w_ctr_base;
                        if (w_eff_first) begin
                            n_pos = '0;
                        end
                        n_ready   = 1'b0;
                        n_applied = 1'b1;
                        n_w       = init_state(i_cfg, w_ctr_base);
                        n_step    = '0;
                        n_half    = 1'b0;
                        n_dr      = '0;
                        n_state   = ST_ROUND;
                    end else if (w_out_free) begin
                        // combine one word with the keystream
                        w_pop       = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_byte  = i_head.data ^ v_word[{r_pos[1:0], 3'b000} +: 8];
                        n_out_last  = i_head.last;
                        n_pos       = r_pos + 6'd1;
                        n_applied   = 1'b0;
                        if (r_pos == 6'd63) begin
                            n_ready = 1'b0;
                        end
                    end
                end
            end
            ST_ROUND: begin
                // one quarter-round step on all four lanes
                for (int l = 0; l < 4; l++) begin
                    v_x      = QR_IDX[r_half][l][r_step];
                    v_y      = QR_IDX[r_half][l][v_ry];
                    v_t      = QR_IDX[r_half][l][v_rt];
                    n_w[v_t] = r_w[v_t] ^ rol_step(r_w[v_x] + r_w[v_y], r_step);
                end
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_half = !r_half;
                    if (r_half) begin
                        n_dr = r_dr + DR_W'(1);
                        if (r_dr == DR_W'(DOUBLE_ROUNDS - 1)) begin
                            n_state = ST_FINAL;
                        end
                    end
                end
            end
            ST_FINAL: begin
                // feed-forward add, then the block is usable
                for (int i = 0; i < 16; i++) begin
                    n_w[i] = r_w[i] + v_init[i];
                end
                n_ctr   = r_ctr + 64'd1;
                n_ready = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ctr       <= '0;
            r_pos       <= '0;
            r_ready     <= 1'b0;
            r_applied   <= 1'b0;
            r_step      <= '0;
            r_half      <= 1'b0;
            r_dr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ctr       <= n_ctr;
            r_pos       <= n_pos;
            r_ready     <= n_ready;
            r_applied   <= n_applied;
            r_step      <= n_step;
            r_half      <= n_half;
            r_dr        <= n_dr;
            r_out_valid <= n_out_valid;
        end
    end

    // block words and output payload
    always_ff @(posedge i_clk) begin
        r_w        <= n_w;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_pop     = w_pop;
    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_byte;
    assign o_m_last  = r_out_last;

    // checks
    `S20_ASSERT(a_no_pop_busy, (r_state != ST_IDLE) |-> !w_pop)
    `S20_ASSERT(a_pop_needs_block, w_pop |-> (r_ready && w_out_free && !w_eff_first))
    `S20_ASSERT(a_final_ready, (r_state == ST_FINAL) |=> (r_ready && r_state == ST_IDLE))
    `S20_ASSERT(a_pos_hold, (!w_pop && !w_start) |=> $stable(r_pos))
    `S20_ASSERT_RST(a_rst_clear, !i_rst_n |=> (r_state == ST_IDLE && !r_out_valid))

endmodule

// ===== rtl/salsa20_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// salsa20_stream_cipher
// salsa20 byte stream cipher with 256-bit key and 64-bit nonce
// ----------------------------------------------------------------------------
// Each input byte is xored with the next salsa20 keystream byte; the same
// path encrypts and decrypts. A tuser flag on a byte restarts the block
// counter and byte position before that byte. Key and nonce are written
// through the cfg channel (index 0..3 key parts, 4 nonce); the user must
// write them only while idle; the block itself does not enforce it. A
// byte is registered and leaves in the cycle after it is taken from the
// queue, so the stream runs one byte per cycle in a block while the output
// is not stalled. Every 64 bytes (and on a first flag) the core builds a
// new block: load, quarter-round steps on four shared lanes, feed-forward.
// ----------------------------------------------------------------------------
module salsa20_stream_cipher
    import s20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] first_of_message
    input  logic        s_tlast,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast
);

    t_cfg  w_cfg;
    t_item w_item;
    t_item w_head;
    logic  w_head_valid;
    logic  w_pop;

    assign o_cfg_ready = 1'b1;

    // pack the incoming word
    assign w_item.data  = s_tdata;
    assign w_item.first = s_tuser[0];
    assign w_item.last  = s_tlast;

    s20_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    s20_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_tvalid),
        .o_ready      (s_tready),
        .i_item       (w_item),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    s20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_m_valid    (m_tvalid),
        .i_m_ready    (m_tready),
        .o_m_data     (m_tdata),
        .o_m_last     (m_tlast)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the salsa20 byte stream cipher
// ----------------------------------------------------------------------------
// Key and nonce settings are loaded over the cfg channel while the core is
// idle. Byte words are streamed in with random first and last flags and
// random gaps, and the output stalls at random. A keystream tracker computes
// each salsa20 block itself and checks every output byte and last flag in
// order. A watchdog ends the run when the handshakes stop moving.
// ----------------------------------------------------------------------------

import s20_pkg::*;

// one expected output word
typedef struct packed {
    logic [7:0] text;
    logic       last;
} t_cipher_word;

// keystream tracker: own copy of key, nonce, counter and current block
class keystream_tracker;
    logic [63:0]  key_part [4];
    logic [63:0]  nonce;
    logic [31:0]  block_words [16];
    logic [31:0]  mix [16];
    logic [63:0]  block_ctr;
    logic [5:0]   byte_pos;
    bit           have_block;
    t_cipher_word pending_bytes [$];
    int           mismatches;

    function new();
        foreach (key_part[i]) key_part[i] = '0;
        nonce      = '0;
        block_ctr  = '0;
        byte_pos   = '0;
        have_block = 1'b0;
        mismatches = 0;
    endfunction

    function int pending();
        return pending_bytes.size();
    endfunction

    // out-of-range indexes leave every register unchanged
    function void set_reg(logic [2:0] idx, logic [63:0] value);
        case (idx)
            REG_KEY_0: key_part[0] = value;
            REG_KEY_1: key_part[1] = value;
            REG_KEY_2: key_part[2] = value;
            REG_KEY_3: key_part[3] = value;
            REG_NONCE: nonce = value;
            default: ;
        endcase
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
        mix[b] = mix[b] ^ rotl(mix[a] + mix[d], 7);
        mix[c] = mix[c] ^ rotl(mix[b] + mix[a], 9);
        mix[d] = mix[d] ^ rotl(mix[c] + mix[b], 13);
        mix[a] = mix[a] ^ rotl(mix[d] + mix[c], 18);
    endfunction

    // next keystream block from constants, key, nonce and counter
    function void build_block();
        logic [31:0] seed [16];
        seed[0]  = SIGMA_0;
        seed[1]  = key_part[0][31:0];
        seed[2]  = key_part[0][63:32];
        seed[3]  = key_part[1][31:0];
        seed[4]  = key_part[1][63:32];
        seed[5]  = SIGMA_1;
        seed[6]  = nonce[31:0];
        seed[7]  = nonce[63:32];
        seed[8]  = block_ctr[31:0];
        seed[9]  = block_ctr[63:32];
        seed[10] = SIGMA_2;
        seed[11] = key_part[2][31:0];
        seed[12] = key_part[2][63:32];
        seed[13] = key_part[3][31:0];
        seed[14] = key_part[3][63:32];
        seed[15] = SIGMA_3;
        foreach (seed[i]) mix[i] = seed[i];
        for (int r = 0; r < DOUBLE_ROUNDS_DEF; r++) begin
            // column round
            quarter(0, 4, 8, 12);
            quarter(5, 9, 13, 1);
            quarter(10, 14, 2, 6);
            quarter(15, 3, 7, 11);
            // row round
            quarter(0, 1, 2, 3);
            quarter(5, 6, 7, 4);
            quarter(10, 11, 8, 9);
            quarter(15, 12, 13, 14);
        end
        foreach (seed[i]) block_words[i] = mix[i] + seed[i];
        block_ctr  = block_ctr + 64'd1;
        have_block = 1'b1;
    endfunction

    // accepted input word: work out the output it must produce
    function void note_plain(logic [7:0] data, logic first, logic last);
        logic [31:0]  word;
        t_cipher_word exp_word;
        if (first) begin
            block_ctr  = '0;
            byte_pos   = '0;
            have_block = 1'b0;
        end
        if (!have_block) build_block();
        word = block_words[byte_pos[5:2]] >> {byte_pos[1:0], 3'b000};
        exp_word.text = data ^ word[7:0];
        exp_word.last = last;
        pending_bytes.push_back(exp_word);
        byte_pos = byte_pos + 6'd1;
        if (byte_pos == 6'd0) have_block = 1'b0;
    endfunction

    // accepted output word against the oldest expectation
    function void check_cipher(logic [7:0] text, logic last);
        t_cipher_word exp_word;
        if (pending_bytes.size() == 0) begin
            $display("%0t unexpected output word: expected none, actual %02h last %0b",
                     $time, text, last);
            mismatches++;
            return;
        end
        exp_word = pending_bytes.pop_front();
        if (text !== exp_word.text) begin
            $display("%0t out_byte: expected %02h, actual %02h",
                     $time, exp_word.text, text);
            mismatches++;
        end
        if (last !== exp_word.last) begin
            $display("%0t out_last: expected %0b, actual %0b",
                     $time, exp_word.last, last);
            mismatches++;
        end
    endfunction
endclass

module tb;

    localparam int          PHASE_ITEMS   = 20;
    localparam int          SETTLE_CYCLES = 200;
    localparam int          QUIET_LIMIT   = 4000;
    localparam logic [2:0]  REG_SPARE_LO  = 3'd5;
    localparam logic [2:0]  REG_SPARE_HI  = 3'd7;
    localparam logic [63:0] ALL_ONES      = {64{1'b1}};

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data  = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;   // [7:0] data_byte
    logic [0:0]  s_tuser     = '0;   // [0] first_of_message
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;            // [7:0] out_byte
    logic        m_tlast;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int quiet_cycles   = 0;

    keystream_tracker tracker = new();

    salsa20_stream_cipher #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS_DEF)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // output side backpressure
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // output checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            tracker.check_cipher(m_tdata, m_tlast);
        end
    end

    // watchdog on stalled handshakes
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one register write on the cfg channel
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one input word, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= data;
        s_tuser[0] <= first;
        s_tlast    <= last;
        do @(posedge i_clk); while (!s_tready);
        tracker.note_plain(data, first, last);
    endtask

    // stop sending and let every expected word come out
    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
            default: begin src_idle_pct = 32; sink_stall_pct = 32; end
        endcase
    endtask

    // mostly well-formed messages, some short runs with random flags
    task automatic random_traffic(input int quota, input bit pause_midway);
        int sent;
        int len;
        bit lead;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(9) < 8) begin
                len  = ($urandom_range(3) == 0) ? $urandom_range(140, 65)
                                                : $urandom_range(40, 1);
                // the first run of a phase often continues the previous stream
                lead = (sent == 0) ? 1'($urandom_range(1)) : ($urandom_range(19) != 0);
                for (int k = 0; k < len; k++) begin
                    send_byte(8'($urandom_range(255)), lead && (k == 0), k == len - 1);
                end
            end else begin
                len = $urandom_range(6, 1);
                for (int k = 0; k < len; k++) begin
                    send_byte(8'($urandom_range(255)), $urandom_range(3) == 0,
                              1'($urandom_range(1)));
                end
            end
            sent += len;
            if (pause_midway && sent >= quota / 2) begin
                pause_midway = 1'b0;
                wait_drained();
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset key and nonce, stream starts with no first flag
        set_idle(0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        send_byte(8'h80, 1'b1, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b0);
        send_byte(8'hFE, 1'b0, 1'b1);
        // single-word message, then restart twice in a row
        send_byte(8'hC3, 1'b1, 1'b1);
        send_byte(8'h3C, 1'b1, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        // last mark with no first in front of it
        send_byte(8'h5A, 1'b0, 1'b1);

        for (int phase = 1; phase <= 8; phase++) begin
            wait_drained();
            case (phase)
                1: begin
                    // all-ones key and nonce, plus writes to unused indexes
                    write_reg(REG_KEY_0, ALL_ONES);
                    write_reg(REG_KEY_1, ALL_ONES);
                    write_reg(REG_KEY_2, ALL_ONES);
                    write_reg(REG_KEY_3, ALL_ONES);
                    write_reg(REG_NONCE, ALL_ONES);
                    for (int j = REG_SPARE_LO; j <= REG_SPARE_HI; j++) begin
                        write_reg(3'(j), {$urandom, $urandom});
                    end
                end
                4: begin
                    // nonce alone changes while a block may be in hand
                    write_reg(REG_NONCE, {$urandom, $urandom});
                    write_reg(REG_SPARE_HI, ALL_ONES);
                end
                8: begin
                    // back to all zeros
                    write_reg(REG_KEY_0, '0);
                    write_reg(REG_KEY_1, '0);
                    write_reg(REG_KEY_2, '0);
                    write_reg(REG_KEY_3, '0);
                    write_reg(REG_NONCE, '0);
                end
                default: begin
                    write_reg(REG_KEY_0, {$urandom, $urandom});
                    write_reg(REG_KEY_1, {$urandom, $urandom});
                    write_reg(REG_KEY_2, {$urandom, $urandom});
                    write_reg(REG_KEY_3, {$urandom, $urandom});
                    write_reg(REG_NONCE, {$urandom, $urandom});
                end
            endcase
            set_idle(phase % 4);
            random_traffic(PHASE_ITEMS, phase == 3);
        end

        wait_drained();
        if (tracker.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/s20_pkg.sv
rtl/s20_regs.sv
rtl/s20_front.sv
rtl/s20_core.sv
rtl/salsa20_stream_cipher.sv
tb/sv/tb.sv
